// ===== sv/byte_value_frequency_table_macros.svh =====
// Assertion macros for the byte value frequency table RTL.
// Depends on nothing; each user supplies clk and rst_n in its own scope.
`ifndef BYTE_VALUE_FREQUENCY_TABLE_MACROS_SVH
`define BYTE_VALUE_FREQUENCY_TABLE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define BVFT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define BVFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bvft_pkg.sv =====
// Package for the byte value frequency table: field widths and the token
// that travels along the chain of cells. Depends on nothing.
`timescale 1ns / 1ps

package bvft_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int INDEX_OUT_W = 4;
    localparam int USED_OUT_W  = 5;

    // Fixed-width part of a beat as it walks the row of cells.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic               inserted;
        logic [BYTE_W-1:0]  byte_value;
        logic [COUNT_W-1:0] count;
    } bvft_token_t;

endpackage

// ===== sv/bvft_cell.sv =====
// One cell of the table: holds a single value and its count, compares the
// passing beat with it and hands the beat on. Depends on bvft_pkg.
`timescale 1ns / 1ps

module bvft_cell
    import bvft_pkg::*;
#(
    parameter int CELL_INDEX = 0,
    parameter int IDX_W      = 4,
    parameter int USED_W     = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bvft_token_t         tok_in,
    input  logic [IDX_W-1:0]    idx_in,
    input  logic [USED_W-1:0]   used_in,
    output bvft_token_t         tok_out,
    output logic [IDX_W-1:0]    idx_out,
    output logic [USED_W-1:0]   used_out,
    output logic [BYTE_W-1:0]   value_out,
    output logic [COUNT_W-1:0]  count_out
);

    logic [BYTE_W-1:0]  value_reg;
    logic [COUNT_W-1:0] count_reg;
    bvft_token_t        tok_reg;
    bvft_token_t        tok_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [USED_W-1:0]  used_reg;
    logic               occupied;
    logic               free_here;
    logic               hit;
    logic               ins;
    logic [COUNT_W-1:0] count_inc;

    assign occupied  = used_in > USED_W'(CELL_INDEX);
    assign free_here = used_in == USED_W'(CELL_INDEX);
    assign hit       = tok_in.valid && !tok_in.found && occupied
                       && (value_reg == tok_in.byte_value);
    assign ins       = tok_in.valid && !tok_in.found && free_here;
    assign count_inc = count_reg + COUNT_W'(1);

    always_comb
    begin
        tok_next = tok_in;
        idx_next = idx_in;
        if (hit)
        begin
            tok_next.found = 1'b1;
            tok_next.count = count_inc;
            idx_next       = IDX_W'(CELL_INDEX);
        end
        else if (ins)
        begin
            tok_next.found    = 1'b1;
            tok_next.inserted = 1'b1;
            tok_next.count    = COUNT_W'(1);
            idx_next          = IDX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            idx_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            tok_reg  <= tok_next;
            idx_reg  <= idx_next;
            used_reg <= used_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            count_reg <= count_inc;
        end
        else if (ins)
        begin
            value_reg <= tok_in.byte_value;
            count_reg <= COUNT_W'(1);
        end
    end

    assign tok_out   = tok_reg;
    assign idx_out   = idx_reg;
    assign used_out  = used_reg;
    assign value_out = value_reg;
    assign count_out = count_reg;

endmodule

// ===== sv/byte_value_frequency_table.sv =====
// Byte value frequency table: a row of TABLE_ENTRIES cells, one per entry.
// Each accepted beat walks the row one cell per cycle, and its result is
// given on done once it leaves the last cell. A new beat is accepted only
// while busy is low; busy stays high while a beat is in flight.
// Reset (rst_n, asynchronous, active low) empties the table and clears busy.
// Results are strobed for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps

module byte_value_frequency_table
    import bvft_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [BYTE_W-1:0]       byte_value,
    input  logic                    first_of_buffer,
    output logic                    busy,
    output logic                    done,
    output logic                    matched,
    output logic                    dropped,
    output logic [INDEX_OUT_W-1:0]  entry_index,
    output logic [COUNT_W-1:0]      entry_count,
    output logic [USED_OUT_W-1:0]   entries_used,
    output logic [BYTE_W-1:0]       head_value,
    output logic [COUNT_W-1:0]      head_count
);

    `include "byte_value_frequency_table_macros.svh"

    // Width of an entry index, and of the fill count that can hold the depth.
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

    // Of the table contents only the fill count has a defined reset. Entries at
    // or above it are never compared, so the cell storage needs no reset.
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;
    logic              busy_reg;
    logic              busy_next;
    logic              accept;

    bvft_token_t       tok_chain  [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]  idx_chain  [0:TABLE_ENTRIES];
    logic [USED_W-1:0] used_chain [0:TABLE_ENTRIES];
    logic [BYTE_W-1:0]  cell_value [0:TABLE_ENTRIES-1];
    logic [COUNT_W-1:0] cell_count [0:TABLE_ENTRIES-1];

    bvft_token_t       tok_end;
    logic [31:0]       idx_wide;
    logic [31:0]       used_wide;

    assign accept = start && !busy_reg;

    // The beat enters cell zero straight from the ports: valid, not yet found,
    // not inserted, the byte itself and a zero count. It carries the fill
    // count as seen by this beat, already emptied when it opens a buffer, so
    // every cell knows whether it is occupied or the first free place.
    assign tok_chain[0]  = {accept, 1'b0, 1'b0, byte_value, {COUNT_W{1'b0}}};
    assign idx_chain[0]  = '0;
    assign used_chain[0] = first_of_buffer ? '0 : used_reg;

    for (genvar k = 0; k < TABLE_ENTRIES; k++)
    begin : g_cell
        bvft_cell #(
            .CELL_INDEX (k),
            .IDX_W      (IDX_W),
            .USED_W     (USED_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .tok_in    (tok_chain[k]),
            .idx_in    (idx_chain[k]),
            .used_in   (used_chain[k]),
            .tok_out   (tok_chain[k+1]),
            .idx_out   (idx_chain[k+1]),
            .used_out  (used_chain[k+1]),
            .value_out (cell_value[k]),
            .count_out (cell_count[k])
        );
    end

    assign tok_end = tok_chain[TABLE_ENTRIES];

    // Once the beat leaves the last cell the outcome is final: it either hit,
    // took the first free cell, or found the table full and was dropped.
    assign used_next = tok_end.valid
                       ? used_chain[TABLE_ENTRIES] + USED_W'(tok_end.inserted)
                       : used_reg;

    // Busy rises with an accepted beat and falls as its result is strobed.
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tok_end.valid)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            busy_reg <= busy_next;
        end
    end

    // Output fields are masked to their port widths, as for wide tables.
    assign idx_wide  = 32'(idx_chain[TABLE_ENTRIES]);
    assign used_wide = 32'(used_next);

    assign busy         = busy_reg;
    assign done         = tok_end.valid;
    assign matched      = tok_end.found && !tok_end.inserted;
    assign dropped      = !tok_end.found;
    assign entry_index  = idx_wide[INDEX_OUT_W-1:0];
    assign entry_count  = tok_end.count;
    assign entries_used = used_wide[USED_OUT_W-1:0];

    // Cell zero has finished with this beat long before the result appears.
    assign head_value = (used_next != '0) ? cell_value[0] : '0;
    assign head_count = (used_next != '0) ? cell_count[0] : '0;

    `BVFT_ASSERT_ALWAYS(a_done_while_busy, !done || busy_reg,
        "result strobed while no beat was in flight")
    `BVFT_ASSERT_ALWAYS(a_outcome_exclusive, !(done && matched && dropped),
        "a beat both matched and was dropped")
    `BVFT_ASSERT_ALWAYS(a_fill_in_range, used_reg <= USED_W'(TABLE_ENTRIES),
        "fill count exceeds the table depth")
    `BVFT_ASSERT_NEXT(a_accept_sets_busy, accept, busy_reg,
        "busy did not rise after an accepted beat")
    `BVFT_ASSERT_NEXT(a_done_clears_busy, done, !busy_reg && !done,
        "busy held or result repeated after the strobe")

endmodule
